// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the median filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RHMF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RHMF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RHMF_ASSERT(lbl, clk, rst, prop, msg)
`define RHMF_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

// ----- rtl/core/rhmf_pkg.sv -----
// Shared constants and types of the RGB histogram median filter.
package rhmf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_RADIUS = 7;
   localparam int QUEUE_DEPTH    = 2;

   localparam int PIX_W  = 8;
   localparam int RGB_W  = 3 * PIX_W;
   localparam int COL_W  = 13;
   localparam int ROW_W  = 13;
   localparam int LW_W   = 14;
   localparam int RAD_W  = 3;
   localparam int SLOT_W = 6;
   localparam int DIFF_W = 17;
   localparam int CNT_W  = 10;
   localparam int BIT_W  = 3;

   // config register fields
   localparam int FW_W  = 11;
   localparam int FH_W  = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HEIGHT  = 2'd3;

   localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
   localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
   localparam logic [RAD_W-1:0] RST_HALF_WIDTH   = 3'd1;
   localparam logic [RAD_W-1:0] RST_HALF_HEIGHT  = 3'd1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // rows kept in the line store: window, plus slack for jobs in flight
   function automatic int line_rows(input int radius);
      return 2 * radius + 2 * QUEUE_DEPTH + 4;
   endfunction

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  col;
      logic [RGB_W-1:0]  data;
   } mem_wr_type;

   typedef struct packed {
      logic [COL_W-1:0]  x;
      logic [ROW_W-1:0]  y;
      logic [SLOT_W-1:0] slot;
      logic [LW_W-1:0]   lw;
      logic [ROW_W-1:0]  lh;
      logic [RAD_W-1:0]  hw;
      logic [RAD_W-1:0]  hh;
      logic              row_end;
      logic              frame_end;
   } job_type;

endpackage

// ----- rtl/core/rhmf_front.sv -----
// Front end: config registers, line store writes, output scheduling.
module rhmf_front #(
   parameter int MAX_WIDTH  = rhmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = rhmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rhmf_pkg::RGB_W-1:0]        req_tdata,
   input  logic                              req_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rhmf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rhmf_pkg::CSR_DATA_W-1:0]   csr_data,
   output rhmf_pkg::mem_wr_type              mem_wr,
   output rhmf_pkg::job_type                 job,
   output logic                              job_push,
   input  logic                              q_ready
);
   import rhmf_pkg::*;

   localparam int LINE_ROWS = line_rows(MAX_RADIUS);

   logic [FW_W-1:0]   cfg_fw_ff;
   logic [FH_W-1:0]   cfg_fh_ff;
   logic [RAD_W-1:0]  cfg_hw_ff, cfg_hh_ff;
   logic [LW_W-1:0]   lw_ff;
   logic [ROW_W-1:0]  lh_ff;
   logic [RAD_W-1:0]  hw_ff, hh_ff;
   logic [COL_W-1:0]  ic_ff, oc_ff;
   logic [ROW_W-1:0]  ir_ff, or_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff;
   logic [DIFF_W-1:0] diff_ff;

   logic [COL_W-1:0]  ic_in, oc_in;
   logic [ROW_W-1:0]  ir_in, or_in;
   logic [SLOT_W-1:0] in_slot_in, out_slot_in;
   logic [DIFF_W-1:0] diff_in;

   logic [LW_W-1:0]   e_lw, cur_lw;
   logic [ROW_W-1:0]  e_lh, cur_lh;
   logic [RAD_W-1:0]  e_hw, e_hh, cur_hw, cur_hh, cur_hx;
   logic [DIFF_W-1:0] cur_lag;
   logic              accept, start, do_write, all_in, emit;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(LINE_ROWS - 1)) ? '0 : s + 1'b1;
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = q_ready;
   assign accept     = req_tvalid && req_tready;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_fw_ff <= RST_FRAME_WIDTH;
         cfg_fh_ff <= RST_FRAME_HEIGHT;
         cfg_hw_ff <= RST_HALF_WIDTH;
         cfg_hh_ff <= RST_HALF_HEIGHT;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_fw_ff <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: cfg_fh_ff <= csr_data[FH_W-1:0];
            CSR_HALF_WIDTH:   cfg_hw_ff <= csr_data[RAD_W-1:0];
            CSR_HALF_HEIGHT:  cfg_hh_ff <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // effective frame geometry
   always_comb begin
      if (cfg_fw_ff == '0)
         e_lw = LW_W'(1);
      else if (LW_W'(cfg_fw_ff) > LW_W'(MAX_WIDTH))
         e_lw = LW_W'(MAX_WIDTH);
      else
         e_lw = LW_W'(cfg_fw_ff);
      e_lh = (cfg_fh_ff == '0) ? ROW_W'(1) : cfg_fh_ff;
      e_hw = (5'(cfg_hw_ff) > 5'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_hw_ff;
      e_hh = (5'(cfg_hh_ff) > 5'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_hh_ff;
   end

   assign start = (req_tuser == OP_PIXEL) && (ir_ff == '0) && (ic_ff == '0)
                  && (or_ff == '0) && (oc_ff == '0);
   assign cur_lw = start ? e_lw : lw_ff;
   assign cur_lh = start ? e_lh : lh_ff;
   assign cur_hw = start ? e_hw : hw_ff;
   assign cur_hh = start ? e_hh : hh_ff;
   assign cur_hx = (LW_W'(cur_hw) < cur_lw - 1'b1) ? cur_hw : RAD_W'(cur_lw - 1'b1);
   assign cur_lag = DIFF_W'(cur_hh) * DIFF_W'(cur_lw) + DIFF_W'(cur_hx);

   // counter update for one request
   always_comb begin
      ic_in       = ic_ff;
      ir_in       = ir_ff;
      oc_in       = oc_ff;
      or_in       = or_ff;
      in_slot_in  = in_slot_ff;
      out_slot_in = out_slot_ff;
      diff_in     = diff_ff;
      do_write    = (req_tuser == OP_PIXEL) && (ir_ff < cur_lh);
      if (do_write) begin
         diff_in = diff_ff + 1'b1;
         if (LW_W'(ic_ff) + 1'b1 >= cur_lw) begin
            ic_in      = '0;
            ir_in      = ir_ff + 1'b1;
            in_slot_in = slot_inc(in_slot_ff);
         end else begin
            ic_in = ic_ff + 1'b1;
         end
      end
      all_in = (ir_in >= cur_lh);
      emit   = all_in || (diff_in > cur_lag);
      if (emit) begin
         diff_in = diff_in - 1'b1;
         if (LW_W'(oc_ff) + 1'b1 >= cur_lw) begin
            oc_in       = '0;
            or_in       = or_ff + 1'b1;
            out_slot_in = slot_inc(out_slot_ff);
         end else begin
            oc_in = oc_ff + 1'b1;
         end
         // frame done: counters restart, line store slots carry on
         if (or_in >= cur_lh) begin
            ic_in       = '0;
            ir_in       = '0;
            oc_in       = '0;
            or_in       = '0;
            diff_in     = '0;
            out_slot_in = in_slot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff       <= '0;
         ir_ff       <= '0;
         oc_ff       <= '0;
         or_ff       <= '0;
         in_slot_ff  <= '0;
         out_slot_ff <= '0;
         diff_ff     <= '0;
         lw_ff       <= LW_W'(1);
         lh_ff       <= ROW_W'(1);
         hw_ff       <= '0;
         hh_ff       <= '0;
      end else if (accept) begin
         ic_ff       <= ic_in;
         ir_ff       <= ir_in;
         oc_ff       <= oc_in;
         or_ff       <= or_in;
         in_slot_ff  <= in_slot_in;
         out_slot_ff <= out_slot_in;
         diff_ff     <= diff_in;
         lw_ff       <= cur_lw;
         lh_ff       <= cur_lh;
         hw_ff       <= cur_hw;
         hh_ff       <= cur_hh;
      end
   end

   // line store write and output job
   always_comb begin
      mem_wr.en   = accept && do_write;
      mem_wr.slot = in_slot_ff;
      mem_wr.col  = ic_ff;
      mem_wr.data = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
      job.x         = oc_ff;
      job.y         = or_ff;
      job.slot      = out_slot_ff;
      job.lw        = cur_lw;
      job.lh        = cur_lh;
      job.hw        = cur_hw;
      job.hh        = cur_hh;
      job.row_end   = (LW_W'(oc_ff) == cur_lw - 1'b1);
      job.frame_end = job.row_end && (or_ff == cur_lh - 1'b1);
   end
   assign job_push = accept && emit;

endmodule

// ----- rtl/core/rhmf_queue.sv -----
// Short job queue between front end and median engine.
`include "assert_macros.svh"
module rhmf_queue #(
   parameter int DEPTH = rhmf_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rhmf_pkg::job_type push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output rhmf_pkg::job_type pop_data
);
   import rhmf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   job_type            store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_QW-1:0]  count_ff;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != CNT_QW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         if (pop)
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         store_ff[wr_ptr_ff] <= push_data;
   end

   `RHMF_ASSERT(a_q_no_overflow, clock, reset, !(push && !push_ready), "queue overflow")
   `RHMF_ASSERT(a_q_no_underflow, clock, reset, !(pop && !pop_valid), "queue underflow")
   `RHMF_ASSERT(a_q_count_bound, clock, reset, count_ff <= CNT_QW'(DEPTH), "queue count")

endmodule

// ----- rtl/core/rhmf_back.sv -----
// Median engine: line store and bitwise rank search over the window.
`include "assert_macros.svh"
module rhmf_back #(
   parameter int MAX_WIDTH  = rhmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = rhmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rhmf_pkg::mem_wr_type        mem_wr,
   input  rhmf_pkg::job_type           job,
   input  logic                        job_valid,
   output logic                        job_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rhmf_pkg::RGB_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   output logic                        rsp_tuser
);
   import rhmf_pkg::*;

   localparam int LINE_ROWS = line_rows(MAX_RADIUS);
   localparam int AW = $clog2(LINE_ROWS * MAX_WIDTH);
   localparam int SW = COL_W + 2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_RUN    = 5'b00010,
      ST_TAIL   = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type          state_ff;
   job_type            job_ff, sel_job;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [BIT_W-1:0]   bit_ff;
   logic [RAD_W:0]     cx_ff, cy_ff;
   logic signed [ROW_W+1:0] t_ff, init_t;
   logic [SLOT_W-1:0]  rslot_ff, init_slot;
   logic [ROW_W-1:0]   init_d;
   logic [PIX_W-1:0]   pv_ff [3];
   logic [CNT_W-1:0]   k_ff [3];
   logic [CNT_W-1:0]   cnt_ff [3];
   logic [PIX_W-1:0]   px [3];
   logic               match [3];
   logic [RGB_W-1:0]   rd_ff;
   logic               rd_vld_ff;
   logic [RGB_W-1:0]   mem [LINE_ROWS * MAX_WIDTH];
   logic [AW-1:0]      waddr, raddr;
   logic signed [SW-1:0] sx, lw_m1;
   logic [COL_W-1:0]   rx;
   logic [PIX_W-1:0]   himask;
   logic               last_x, last_y, out_load;
   logic [SLOT_W:0]    slot_wide;

   // line store
   assign waddr = AW'(mem_wr.slot) * AW'(MAX_WIDTH) + AW'(mem_wr.col);
   always_ff @(posedge clock) begin
      if (mem_wr.en)
         mem[waddr] <= mem_wr.data;
   end
   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN)
         rd_ff <= mem[raddr];
   end

   // pass start position: clamped top row of the window
   assign sel_job = (state_ff == ST_IDLE) ? job : job_ff;
   always_comb begin
      init_d = (ROW_W'(sel_job.hh) > sel_job.y) ? sel_job.y : ROW_W'(sel_job.hh);
      init_t = $signed({2'b00, sel_job.y}) - $signed((ROW_W + 2)'(sel_job.hh));
      if ((SLOT_W + 1)'(sel_job.slot) >= (SLOT_W + 1)'(init_d))
         slot_wide = (SLOT_W + 1)'(sel_job.slot) - (SLOT_W + 1)'(init_d);
      else
         slot_wide = (SLOT_W + 1)'(sel_job.slot) + (SLOT_W + 1)'(LINE_ROWS)
                     - (SLOT_W + 1)'(init_d);
      init_slot = slot_wide[SLOT_W-1:0];
      n_in = CNT_W'({sel_job.hw, 1'b1}) * CNT_W'({sel_job.hh, 1'b1});
   end

   // clamped column and read address
   always_comb begin
      sx    = $signed(SW'(job_ff.x)) + $signed(SW'(cx_ff)) - $signed(SW'(job_ff.hw));
      lw_m1 = $signed(SW'(job_ff.lw)) - SW'(1);
      if (sx < 0)
         rx = '0;
      else if (sx > lw_m1)
         rx = lw_m1[COL_W-1:0];
      else
         rx = sx[COL_W-1:0];
      raddr  = AW'(rslot_ff) * AW'(MAX_WIDTH) + AW'(rx);
      last_x = (cx_ff == {1'b0, job_ff.hw} << 1);
      last_y = (cy_ff == {1'b0, job_ff.hh} << 1);
   end

   // per-channel compare against the current prefix
   assign himask = 8'hFF << (4'(bit_ff) + 4'd1);
   assign px[0]  = rd_ff[23:16];
   assign px[1]  = rd_ff[15:8];
   assign px[2]  = rd_ff[7:0];
   always_comb begin
      for (int c = 0; c < 3; c++)
         match[c] = (((px[c] ^ pv_ff[c]) & himask) == '0) && !px[c][bit_ff];
   end

   assign job_pop  = (state_ff == ST_IDLE) && job_valid;
   assign out_load = (state_ff == ST_DONE) && (!rsp_tvalid || rsp_tready);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == ST_RUN);
         if (out_load)
            rsp_tvalid <= 1'b1;
         else if (rsp_tready)
            rsp_tvalid <= 1'b0;
         case (state_ff)
            ST_IDLE:   if (job_valid) state_ff <= ST_RUN;
            ST_RUN:    if (last_x && last_y) state_ff <= ST_TAIL;
            ST_TAIL:   state_ff <= ST_UPDATE;
            ST_UPDATE: state_ff <= (bit_ff == '0) ? ST_DONE : ST_RUN;
            ST_DONE:   if (out_load) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            job_ff   <= job;
            n_ff     <= n_in;
            bit_ff   <= BIT_W'(PIX_W - 1);
            cx_ff    <= '0;
            cy_ff    <= '0;
            t_ff     <= init_t;
            rslot_ff <= init_slot;
            for (int c = 0; c < 3; c++) begin
               pv_ff[c]  <= '0;
               k_ff[c]   <= (n_in + 1'b1) >> 1;
               cnt_ff[c] <= '0;
            end
         end
         ST_RUN: begin
            if (last_x) begin
               cx_ff <= '0;
               cy_ff <= cy_ff + 1'b1;
               t_ff  <= t_ff + (ROW_W + 2)'(1);
               if (t_ff >= 0 && t_ff + 1 <= $signed({2'b00, job_ff.lh}) - 1)
                  rslot_ff <= (rslot_ff == SLOT_W'(LINE_ROWS - 1)) ? '0
                              : rslot_ff + 1'b1;
            end else begin
               cx_ff <= cx_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            for (int c = 0; c < 3; c++) begin
               if (k_ff[c] > cnt_ff[c]) begin
                  k_ff[c]  <= k_ff[c] - cnt_ff[c];
                  pv_ff[c] <= pv_ff[c] | (PIX_W'(1) << bit_ff);
               end
               cnt_ff[c] <= '0;
            end
            bit_ff   <= bit_ff - 1'b1;
            cx_ff    <= '0;
            cy_ff    <= '0;
            t_ff     <= init_t;
            rslot_ff <= init_slot;
         end
         default: ;
      endcase
      if (rd_vld_ff) begin
         for (int c = 0; c < 3; c++)
            if (match[c])
               cnt_ff[c] <= cnt_ff[c] + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata <= {pv_ff[2], pv_ff[1], pv_ff[0]};
         rsp_tlast <= job_ff.row_end;
         rsp_tuser <= job_ff.frame_end;
      end
   end

   `RHMF_ASSERT(a_cnt_bound, clock, reset, (state_ff == ST_IDLE) || (cnt_ff[0] <= n_ff),
                "pass count exceeds window size")
   `RHMF_ASSERT(a_rank_live, clock, reset,
                (state_ff == ST_IDLE) || (k_ff[0] != '0 && k_ff[1] != '0 && k_ff[2] != '0),
                "rank dropped to zero")
   `RHMF_ASSERT_NEXT(a_done_after_lsb, clock, reset,
                     (state_ff == ST_UPDATE) && (bit_ff == '0), state_ff == ST_DONE,
                     "search did not finish after last bit")

endmodule

// ----- rtl/core/rgb_histogram_median_filter_top.sv -----
// RGB median filter: request stream in, per-channel window median out.
//
// req_*: one request per pixel in raster order (tuser 0) or a drain tick
//   (tuser 1) that pulls out a pending output after the frame is in.
// rsp_*: one median pixel per output position; tlast marks row end, tuser
//   marks frame end. csr_*: writes frame width/height and window radii,
//   applied when the next frame starts; csr_ready is always high.
// Output (y,x) is produced by the request that completes its window. For
//   each output the single read port of the line store is visited once per
//   window pixel for each of the 8 bits of the median search, all three
//   channels side by side.
// A two-entry job queue lets requests be taken while the engine works and
//   while a result waits in the output register; when rsp_tready is low the
//   result holds, the queue fills and req_tready drops.
// Reset returns the counters and config to defaults (640x480, 3x3). The
//   line store needs no clearing; rows are written before they are read.
module rgb_histogram_median_filter_top #(
   parameter int MAX_WIDTH  = rhmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = rhmf_pkg::DEF_MAX_RADIUS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rhmf_pkg::RGB_W-1:0]       req_tdata,  // in_red, in_green, in_blue
   input  logic                             req_tuser,  // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rhmf_pkg::RGB_W-1:0]       rsp_tdata,  // out_red, out_green, out_blue
   output logic                             rsp_tlast,  // row_end
   output logic                             rsp_tuser,  // frame_end
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rhmf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rhmf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rhmf_pkg::*;

   mem_wr_type mem_wr;
   job_type    job_in, job_out;
   logic       job_push, q_ready, job_valid, job_pop;

   rhmf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mem_wr     (mem_wr),
      .job        (job_in),
      .job_push   (job_push),
      .q_ready    (q_ready)
   );

   rhmf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in),
      .push_ready (q_ready),
      .pop        (job_pop),
      .pop_valid  (job_valid),
      .pop_data   (job_out)
   );

   rhmf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mem_wr     (mem_wr),
      .job        (job_out),
      .job_valid  (job_valid),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/rgb_histogram_median_filter_top_test.sv -----
// Self-checking testbench of the RGB window median filter.
`timescale 1ns / 100ps

module rgb_histogram_median_filter_top_test;
   import rhmf_pkg::*;

   localparam int STORE_ROWS  = 16;
   localparam int STORE_COLS  = 1024;
   localparam int CYCLE_LIMIT = 6000000;
   localparam int SETTLE      = 2000;   // longer than one 15x15 median search
   localparam int RANDOM_REQS = 260;

   // one median pixel as it leaves the block
   typedef struct packed {
      logic       frame_end;
      logic       row_end;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } median_pix_type;

   // one row of the directed table
   typedef struct {
      logic           op;
      logic [23:0]    pix;       // blue, green, red from the top bits down
      bit             typed;     // result is written out below, not predicted
      bit             has_rsp;
      median_pix_type rsp;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RGB_W-1:0]      req_tdata = '0;   // in_red, in_green, in_blue
   logic                  req_tuser = OP_PIXEL;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RGB_W-1:0]      rsp_tdata;   // out_red, out_green, out_blue
   logic                  rsp_tlast;   // row_end
   logic                  rsp_tuser;   // frame_end
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   rgb_histogram_median_filter_top dut (.*);

   always #6 clock = ~clock;

   // predictor state: registers, latched frame setup, counters, line store
   logic [10:0] reg_width = 11'd640;
   logic [12:0] reg_height = 13'd480;
   logic [2:0]  reg_hw = 3'd1, reg_hh = 3'd1;
   int          fr_w, fr_h, fr_hw, fr_hh;
   int          in_col, in_row, out_row, out_col;
   logic [23:0] line_store [STORE_ROWS*STORE_COLS];

   median_pix_type expected_medians[$];
   int          errors = 0;
   int          medians_seen = 0;
   int          requests_sent = 0;
   int          frames_done = 0;
   int          cycles = 0;
   bit          quiet = 1'b0;
   bit          hold_start = 1'b0;
   int          hold_left = 0;

   function automatic void latch_frame_setup();
      fr_w  = (reg_width == 0) ? 1 : int'(reg_width);
      if (fr_w > STORE_COLS) fr_w = STORE_COLS;
      fr_h  = (reg_height == 0) ? 1 : int'(reg_height);
      fr_hw = int'(reg_hw);
      fr_hh = int'(reg_hh);
   endfunction

   function automatic bit frame_idle();
      return in_col == 0 && in_row == 0 && out_row == 0 && out_col == 0;
   endfunction

   // median of the window around the next output position, then advance
   function automatic median_pix_type window_median();
      int             hist [3][256];
      int             ry, rx, rank, acc;
      logic [23:0]    p;
      logic [7:0]     med [3];
      median_pix_type m;
      for (int c = 0; c < 3; c++)
         for (int v = 0; v < 256; v++) hist[c][v] = 0;
      for (int dy = -fr_hh; dy <= fr_hh; dy++) begin
         ry = out_row + dy;
         if (ry < 0) ry = 0;
         if (ry > fr_h - 1) ry = fr_h - 1;
         for (int dx = -fr_hw; dx <= fr_hw; dx++) begin
            rx = out_col + dx;
            if (rx < 0) rx = 0;
            if (rx > fr_w - 1) rx = fr_w - 1;
            p = line_store[(ry % STORE_ROWS) * STORE_COLS + rx];
            hist[0][p[7:0]]++;
            hist[1][p[15:8]]++;
            hist[2][p[23:16]]++;
         end
      end
      rank = ((2 * fr_hw + 1) * (2 * fr_hh + 1) + 1) / 2;
      for (int c = 0; c < 3; c++) begin
         acc = 0;
         med[c] = 8'hff;
         for (int v = 0; v < 256; v++) begin
            acc += hist[c][v];
            if (acc >= rank) begin
               med[c] = v[7:0];
               break;
            end
         end
      end
      m.red = med[0];
      m.green = med[1];
      m.blue = med[2];
      m.row_end = (out_col == fr_w - 1);
      m.frame_end = (out_col == fr_w - 1) && (out_row == fr_h - 1);
      out_col++;
      if (out_col >= fr_w) begin
         out_col = 0;
         out_row++;
      end
      if (out_row >= fr_h) begin
         in_col = 0;
         in_row = 0;
         out_row = 0;
         out_col = 0;
      end
      return m;
   endfunction

   // advance the predictor by one request; returns 1 with a median if one is due
   function automatic bit predict_request(input logic op, input logic [23:0] pix,
                                          output median_pix_type m);
      longint in_cnt, out_idx, lag;
      int     hx;
      bit     all_in;
      if (op == OP_PIXEL) begin
         if (frame_idle()) latch_frame_setup();
         if (in_row < fr_h) begin
            line_store[(in_row % STORE_ROWS) * STORE_COLS + in_col] = pix;
            in_col++;
            if (in_col >= fr_w) begin
               in_col = 0;
               in_row++;
            end
         end
      end
      all_in = in_row >= fr_h;
      in_cnt = longint'(in_row) * fr_w + in_col;
      out_idx = longint'(out_row) * fr_w + out_col;
      hx = (fr_hw < fr_w - 1) ? fr_hw : fr_w - 1;
      lag = longint'(fr_hh) * fr_w + hx;
      if (all_in || out_idx + lag < in_cnt) begin
         m = window_median();
         return 1'b1;
      end
      m = '0;
      return 1'b0;
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d medians still expected", $time, expected_medians.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (hold_start)
         hold_left <= 3000;
      else if (hold_left > 0)
         hold_left <= hold_left - 1;
      rsp_tready <= !reset && hold_left == 0 && (quiet || $urandom_range(99) >= 31);
   end

   // result checker
   always @(posedge clock) begin
      median_pix_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tlast, rsp_tdata};
         medians_seen++;
         if (expected_medians.size() == 0) begin
            $display("%0t: unexpected median, got %h", $time, got);
            errors++;
         end else begin
            want = expected_medians.pop_front();
            if (got.red != want.red)
               $display("%0t: red mismatch, expected %h got %h", $time, want.red, got.red);
            if (got.green != want.green)
               $display("%0t: green mismatch, expected %h got %h",
                        $time, want.green, got.green);
            if (got.blue != want.blue)
               $display("%0t: blue mismatch, expected %h got %h", $time, want.blue, got.blue);
            if (got.row_end != want.row_end)
               $display("%0t: row_end mismatch, expected %b got %b",
                        $time, want.row_end, got.row_end);
            if (got.frame_end != want.frame_end)
               $display("%0t: frame_end mismatch, expected %b got %b",
                        $time, want.frame_end, got.frame_end);
            if (got != want) errors++;
         end
      end
   end

   // send one request; the expectation comes from the table or the predictor
   // valid stays high on return so that requests can follow back to back
   task automatic send_request(input logic op, input logic [23:0] pix,
                               input bit typed = 0, input bit has_rsp = 0,
                               input median_pix_type rsp = '0);
      median_pix_type m;
      bit             due;
      while (!quiet && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      due = predict_request(op, pix, m);
      if (typed) begin
         due = has_rsp;
         m = rsp;
      end
      if (due) expected_medians.push_back(m);
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  reg_width = value[10:0];
         CSR_FRAME_HEIGHT: reg_height = value[12:0];
         CSR_HALF_WIDTH:   reg_hw = value[2:0];
         default:          reg_hh = value[2:0];
      endcase
   endtask

   task automatic set_frame(input int w, input int h, input int hw, input int hh);
      wait_drained();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_HALF_WIDTH, hw);
      write_reg(CSR_HALF_HEIGHT, hh);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_level();
      int k;
      k = $urandom_range(9);
      if (k == 0) return 8'h00;
      if (k == 1) return 8'hff;
      return 8'($urandom_range(255));
   endfunction

   // directed table: 1x1 frames with results read off directly, then a 4x3
   // frame whose window is wider than the image, drained by stray pixels and drain ticks
   dir_row_type unit_rows[] = '{
      '{OP_DRAIN, 24'h000000, 1, 0, '0},
      '{OP_PIXEL, 24'h000000, 1, 1, {1'b1, 1'b1, 24'h000000}},
      '{OP_PIXEL, 24'hffffff, 1, 1, {1'b1, 1'b1, 24'hffffff}},
      '{OP_PIXEL, 24'hc35aa5, 1, 1, {1'b1, 1'b1, 24'hc35aa5}},
      '{OP_DRAIN, 24'hffffff, 1, 0, '0}
   };

   logic [23:0] small_pix [12] = '{24'h000000, 24'hffffff, 24'h102030, 24'h80ff01,
                                   24'h7f7f7f, 24'h010203, 24'hfefdfc, 24'h55aa55,
                                   24'haa55aa, 24'h0f0f0f, 24'hf0f0f0, 24'h3c3c3c};

   initial begin
      int w, h, hw, hh, fw, fh, frame_no;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_frame(1, 1, 0, 0);
      foreach (unit_rows[i])
         send_request(unit_rows[i].op, unit_rows[i].pix, unit_rows[i].typed,
                      unit_rows[i].has_rsp, unit_rows[i].rsp);

      // receiver holds off long enough for the queue to fill during this frame
      set_frame(4, 3, 7, 1);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      send_request(OP_DRAIN, 24'h0);
      foreach (small_pix[i]) send_request(OP_PIXEL, small_pix[i]);
      repeat (4) send_request(OP_PIXEL, 24'h123456);
      repeat (6) send_request(OP_DRAIN, 24'h0);

      // random frames
      frame_no = 0;
      while (requests_sent < RANDOM_REQS) begin
         hw = ($urandom_range(9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         hh = ($urandom_range(9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         w = $urandom_range(9) < 8 ? $urandom_range(1, 8) : $urandom_range(0, 24);
         h = $urandom_range(9) < 8 ? $urandom_range(1, 6) : $urandom_range(0, 10);
         if (hw > 2 || hh > 2) begin
            if (w > 5) w = 5;
            if (h > 5) h = 5;
         end
         set_frame(w, h, hw, hh);
         fw = (w == 0) ? 1 : w;
         fh = (h == 0) ? 1 : h;
         quiet = (frame_no >= 3 && frame_no < 6);
         for (int i = 0; i < fw * fh; i++) begin
            if ($urandom_range(99) < 5) send_request(OP_DRAIN, 24'($urandom));
            send_request(OP_PIXEL, {rand_level(), rand_level(), rand_level()});
         end
         while (!frame_idle())
            send_request($urandom_range(9) < 3 ? OP_PIXEL : OP_DRAIN, 24'($urandom));
         if ($urandom_range(4) == 0) send_request(OP_DRAIN, 24'($urandom));
         frames_done++;
         frame_no++;
      end
      quiet = 1'b0;

      // widest row, clamped from the all-ones width
      set_frame(2047, 1, 3, 0);
      for (int i = 0; i < STORE_COLS; i++)
         send_request(OP_PIXEL, {rand_level(), rand_level(), rand_level()});
      while (!frame_idle()) send_request(OP_DRAIN, 24'h0);
      frames_done++;

      // tallest frame, largest radii; only its top is sent
      set_frame(1, 8191, 7, 7);
      for (int i = 0; i < 40; i++) send_request(OP_PIXEL, 24'($urandom));

      wait_drained();
      $display("Sent %0d requests over %0d complete frames and %0d medians were checked.",
               requests_sent, frames_done, medians_seen);
      $display("Covered 1x1 to 1024-wide frames, radii 0 to 7, stray drains and stalls.");
      if (errors == 0 && expected_medians.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d medians missing", errors, expected_medians.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
